@@ src/tcw_pkg.sv @@
// shared types and constants of the text console character writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   value;
        logic                scrolled;
    } t_result;

endpackage

@@ src/tcw_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tcw_ctrl.sv @@
// cursor, row rotation and screen memory sequencer
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [CHAR_W-1:0]  i_char,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [ATTR_W-1:0]  i_attr,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);

    t_state r_state, n_state;

    logic [AW-1:0]     r_lin, n_lin;      // logical cursor
    logic [CW-1:0]     r_col, n_col;      // cursor column
    logic [AW-1:0]     r_base, n_base;    // physical address of the top-left cell
    logic [AW-1:0]     r_cnt, n_cnt;      // sweep counter
    logic [CELL_W-1:0] r_value, n_value;
    logic              r_scrolled, n_scrolled;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic          in_fire;
    t_action       action;
    logic          is_newline;
    logic          last_row;
    logic          last_col;
    logic [31:0]   index_ext;
    logic          index_ok;
    logic [AW-1:0] index_aw;
    logic [AW-1:0] phys_cursor;
    logic [AW-1:0] phys_index;
    logic [31:0]   lin_ext;

    // logical to physical address through the rotating top row
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(CELLS)) begin
            s = s - (AW+1)'(CELLS);
        end
        return s[AW-1:0];
    endfunction

    assign in_fire     = i_in_valid && (r_state == ST_IDLE);
    assign action      = t_action'(i_action);
    assign is_newline  = (i_char == NEWLINE_CODE);
    assign last_row    = (r_lin >= AW'(CELLS - COLUMNS));
    assign last_col    = (r_col == CW'(COLUMNS - 1));
    assign index_ext   = 32'(i_index);
    assign index_ok    = (index_ext < 32'(CELLS));
    assign index_aw    = index_ext[AW-1:0];
    assign phys_cursor = to_phys(r_lin, r_base);
    assign phys_index  = to_phys(index_aw, r_base);
    assign lin_ext     = 32'(r_lin);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_cnt == AW'(CELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (action)
                        ACT_PUT: begin
                            if (last_row && (is_newline || last_col)) n_state = ST_SCROLL;
                            else n_state = ST_DONE;
                        end
                        ACT_CLEAR: n_state = ST_CLEAR;
                        ACT_READ: begin
                            if (index_ok) n_state = ST_READ;
                            else n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_SCROLL: begin
                if (r_cnt == AW'(COLUMNS - 1)) n_state = ST_DONE;
            end
            ST_CLEAR: begin
                if (r_cnt == AW'(CELLS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // outputs and memory port control
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt;
        mem_wdata   = BLANK_CELL;
        mem_re      = 1'b0;
        mem_raddr   = phys_index;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire && action == ACT_PUT && !is_newline) begin
                    mem_we    = 1'b1;
                    mem_waddr = phys_cursor;
                    mem_wdata = {i_attr, i_char};
                end
                if (in_fire && action == ACT_READ && index_ok) begin
                    mem_re = 1'b1;
                end
            end
            ST_SCROLL: begin
                // blank the old top row, it becomes the new bottom row
                mem_we    = 1'b1;
                mem_waddr = r_base + r_cnt;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        n_lin      = r_lin;
        n_col      = r_col;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_value    = r_value;
        n_scrolled = r_scrolled;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                n_cnt = r_cnt + AW'(1);
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_value    = '0;
                    n_scrolled = 1'b0;
                    n_cnt      = '0;
                    unique case (action)
                        ACT_PUT: begin
                            if (is_newline) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_lin      = r_lin - AW'(r_col);
                                    n_scrolled = 1'b1;
                                end else begin
                                    n_lin = r_lin + AW'(COLUMNS) - AW'(r_col);
                                end
                            end else if (last_col) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_lin      = r_lin - AW'(COLUMNS - 1);
                                    n_scrolled = 1'b1;
                                end else begin
                                    n_lin = r_lin + AW'(1);
                                end
                            end else begin
                                n_col = r_col + CW'(1);
                                n_lin = r_lin + AW'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_lin  = '0;
                            n_col  = '0;
                            n_base = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_value = mem_rdata;
            end
            ST_SCROLL: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(COLUMNS - 1)) begin
                    if (r_base == AW'(CELLS - COLUMNS)) n_base = '0;
                    else n_base = r_base + AW'(COLUMNS);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_lin   <= '0;
            r_col   <= '0;
            r_base  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_lin   <= n_lin;
            r_col   <= n_col;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_scrolled <= n_scrolled;
    end

    assign o_res.cursor   = lin_ext[CURSOR_W-1:0];
    assign o_res.value    = r_value;
    assign o_res.scrolled = r_scrolled;

endmodule

@@ src/text_console_char_writer.sv @@
// text console character writer top level
//
//  channel   direction  beat fields (lowest bit first)
//  s_axis    in         tuser: action[1:0]; tdata: char_code[7:0], cell_index[18:8]
//  m_axis    out        tuser: scrolled; tdata: cursor_position[10:0], cell_value[26:11]
//  cfg       in         i_cfg_wdata: text_attribute, written when i_cfg_we is high
//
//  put char without scroll, clear-free actions: go from accept straight to the done state
//  read: passes through the read state for the registered read of the screen ram
//  scroll: one ram write per blanked cell of the recycled row
//  clear: a sweep that blanks every cell; after reset the same sweep runs before the
//  first beat is accepted
//  one action at a time; a finished result waits in the output register
`timescale 1ns / 1ps

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [23:0]       i_s_axis_tdata,  // char_code, cell_index
    input  logic [1:0]        i_s_axis_tuser,  // action
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,  // cursor_position, cell_value
    output logic              o_m_axis_tuser,  // scrolled
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata
);

    logic [ATTR_W-1:0] r_attr;
    logic              r_out_valid;
    t_result           r_out;
    logic              res_valid;
    logic              res_ready;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_char      (i_s_axis_tdata[CHAR_W-1:0]),
        .i_index     (i_s_axis_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
        .i_attr      (r_attr),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output slot frees when empty or when its beat is taken
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.value, r_out.cursor};
    assign o_m_axis_tuser  = r_out.scrolled;

endmodule

@@ tb/tb.sv @@
// testbench for the text console character writer: directed table, random traffic, predictor
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam int COLS          = TCW_COLUMNS;
    localparam int CELLS         = TCW_COLUMNS * TCW_ROWS;
    localparam int N_PHASES      = 5;
    localparam int PHASE_ITEMS   = 300;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int PRINT_MAX     = 20;
    // keep a wide margin over the slowest correct run
    localparam int LIMIT_CYCLES  = 2_000_000;

    // action code that the block leaves unused
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_PATTERN,
        SINK_SPARSE
    } t_sink_mode;

    typedef struct packed {
        logic                cfg;
        logic [ATTR_W-1:0]   attr;
        logic [1:0]          act;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        logic [7:0]          reps;
        t_result             want;   // result of the last repetition
    } t_row;

    localparam int N_DIR = 24;
    localparam t_row DIRECTED [N_DIR] = '{
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd0,    8'd1,  '{11'd0,    16'h0720, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd1999, 8'd1,  '{11'd0,    16'h0720, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'hFF, 11'd2000, 8'd1,  '{11'd0,    16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'hFF, 11'd2047, 8'd1,  '{11'd0,    16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'h41, 11'd2047, 8'd1,  '{11'd1,    16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'h00, 11'd0,    8'd1,  '{11'd2,    16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'hFF, 11'd0,    8'd1,  '{11'd3,    16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd0,    8'd1,  '{11'd3,    16'h0741, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd2,    8'd1,  '{11'd3,    16'h07FF, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'h0A, 11'd0,    8'd1,  '{11'd80,   16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_SPARE, 8'hFF, 11'd2047, 8'd1,  '{11'd80,   16'h0000, 1'b0}},
        '{1'b1, 8'hFF, ACT_PUT,   8'h42, 11'd0,    8'd1,  '{11'd81,   16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd80,   8'd1,  '{11'd81,   16'hFF42, 1'b0}},
        '{1'b1, 8'h00, ACT_PUT,   8'h80, 11'd0,    8'd1,  '{11'd82,   16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd81,   8'd1,  '{11'd82,   16'h0080, 1'b0}},
        '{1'b0, 8'h00, ACT_CLEAR, 8'h00, 11'd0,    8'd1,  '{11'd0,    16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd80,   8'd1,  '{11'd0,    16'h0720, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'h0A, 11'd0,    8'd24, '{11'd1920, 16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'h0A, 11'd0,    8'd1,  '{11'd1920, 16'h0000, 1'b1}},
        '{1'b0, 8'h00, ACT_PUT,   8'h55, 11'd0,    8'd79, '{11'd1999, 16'h0000, 1'b0}},
        '{1'b0, 8'h00, ACT_PUT,   8'h7E, 11'd0,    8'd1,  '{11'd1920, 16'h0000, 1'b1}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd1919, 8'd1,  '{11'd1920, 16'h007E, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd1920, 8'd1,  '{11'd1920, 16'h0720, 1'b0}},
        '{1'b0, 8'h00, ACT_READ,  8'h00, 11'd1840, 8'd1,  '{11'd1920, 16'h0055, 1'b0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // char_code, cell_index
    logic [1:0]  i_s_axis_tuser;   // action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // cursor_position, cell_value
    logic        o_m_axis_tuser;   // scrolled
    logic        i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;

    text_console_char_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // shadow copy of the console
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                shadow_cursor;
    logic [ATTR_W-1:0] shadow_attr;

    t_result console_replies [$];

    int mismatches;
    int beats_checked;
    int cycles;
    int burst_left;
    int n_put, n_read, n_clear, n_spare, n_scroll, n_attr, n_hold;

    logic       hold_req;
    int         hold_left;
    int         sink_left;
    t_sink_mode sink_mode;
    logic [7:0] sink_pat;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
        shadow_cursor = 0;
    endfunction

    task automatic apply_action(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_W-1:0] idx, output t_result res);
        res = '0;
        case (act)
            ACT_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    shadow_cursor += COLS - (shadow_cursor % COLS);
                end else begin
                    shadow_cells[shadow_cursor] = {shadow_attr, ch};
                    shadow_cursor++;
                end
                if (shadow_cursor >= CELLS) begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        shadow_cells[i] = shadow_cells[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        shadow_cells[i] = BLANK_CELL;
                    shadow_cursor -= COLS;
                    res.scrolled = 1'b1;
                    n_scroll++;
                end
            end
            ACT_CLEAR: begin
                blank_screen();
            end
            ACT_READ: begin
                if (idx < CELLS) res.value = shadow_cells[idx];
            end
            default: begin
            end
        endcase
        res.cursor = CURSOR_W'(shadow_cursor);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("tb: mismatch in %s at cycle %0d: got 0x%0h, want 0x%0h",
                     what, cycles, got, want);
    endtask

    // one beat in; the burst counter decides when the sender goes quiet
    task automatic send_action(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                               input logic [INDEX_W-1:0] idx, input logic typed,
                               input t_result want);
        t_result predicted;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = act;
        i_s_axis_tdata  = {5'd0, idx, ch};
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_action(act, ch, idx, predicted);
        console_replies.push_back(typed ? want : predicted);
        case (act)
            ACT_PUT:   n_put++;
            ACT_READ:  n_read++;
            ACT_CLEAR: n_clear++;
            default:   n_spare++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(0, 50);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (console_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_attribute(input logic [ATTR_W-1:0] attr);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = attr;
        shadow_attr = attr;
        n_attr++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // mostly text with newlines, reads anywhere and near the cursor, rare clears and spare codes
    task automatic random_action();
        int                 pick;
        logic [1:0]         act;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(0, 199);
        ch   = CHAR_W'($urandom_range(0, 255));
        idx  = INDEX_W'($urandom_range(0, 2047));
        if (pick == 0) begin
            act = ACT_CLEAR;
        end else if (pick < 5) begin
            act = ACT_SPARE;
        end else if (pick < 50) begin
            act = ACT_READ;
            if (pick < 30)
                idx = INDEX_W'($urandom_range(0, CELLS - 1));
            else if (pick < 42)
                idx = INDEX_W'((shadow_cursor + CELLS - $urandom_range(1, 160)) % CELLS);
        end else begin
            act = ACT_PUT;
            if ($urandom_range(0, 5) == 0) ch = NEWLINE_CODE;
        end
        send_action(act, ch, idx, 1'b0, '0);
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready = 1'b0;
        end else if (hold_req) begin
            hold_req        = 1'b0;
            hold_left       = HOLD_CYCLES;
            i_m_axis_tready = 1'b0;
            n_hold++;
        end else begin
            if (sink_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                sink_left = $urandom_range(16, 200);
                sink_pat  = 8'($urandom) | 8'h01;
            end else begin
                sink_left--;
            end
            case (sink_mode)
                SINK_OPEN: i_m_axis_tready = 1'b1;
                SINK_COIN: i_m_axis_tready = 1'($urandom_range(0, 1));
                SINK_PATTERN: begin
                    i_m_axis_tready = sink_pat[0];
                    sink_pat        = {sink_pat[0], sink_pat[7:1]};
                end
                default: i_m_axis_tready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.cursor   = o_m_axis_tdata[10:0];
            got.value    = o_m_axis_tdata[26:11];
            got.scrolled = o_m_axis_tuser;
            beats_checked++;
            if (console_replies.size() == 0) begin
                report_mismatch("beat with nothing pending", int'(got.cursor), 0);
            end else begin
                want = console_replies.pop_front();
                if (got.cursor != want.cursor)
                    report_mismatch("cursor_position", int'(got.cursor), int'(want.cursor));
                if (got.value != want.value)
                    report_mismatch("cell_value", int'(got.value), int'(want.value));
                if (got.scrolled != want.scrolled)
                    report_mismatch("scrolled", int'(got.scrolled), int'(want.scrolled));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [ATTR_W-1:0] phase_attr;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_PUT;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = ATTR_RESET;
        hold_req        = 1'b0;
        hold_left       = 0;
        sink_left       = 0;
        sink_mode       = SINK_OPEN;
        sink_pat        = 8'hFF;
        burst_left      = 0;
        mismatches      = 0;
        beats_checked   = 0;
        cycles          = 0;
        {n_put, n_read, n_clear, n_spare, n_scroll, n_attr, n_hold} = '0;
        blank_screen();
        shadow_attr = ATTR_RESET;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIRECTED[r].cfg) set_attribute(DIRECTED[r].attr);
            for (int k = 1; k <= DIRECTED[r].reps; k++)
                send_action(DIRECTED[r].act, DIRECTED[r].ch, DIRECTED[r].idx,
                            k == DIRECTED[r].reps, DIRECTED[r].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0)
                phase_attr = 8'hFF;
            else if (ph == 1)
                phase_attr = 8'h00;
            else
                phase_attr = ATTR_W'($urandom_range(0, 255));
            set_attribute(phase_attr);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver goes quiet while the sender keeps pushing
                if (ph == 1 && n == 40) hold_req = 1'b1;
                if (ph == 3 && n == 150) wait_drained();
                random_action();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d beats checked: %0d put, %0d read, %0d clear, %0d spare code",
                 beats_checked, n_put, n_read, n_clear, n_spare);
        $display("tb: %0d scrolls, %0d attribute writes, %0d receiver hold-offs, %0d cycles",
                 n_scroll, n_attr, n_hold, cycles);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_ctrl.sv
src/text_console_char_writer.sv
tb/tb.sv
